FILE: rtl/qau_pkg.sv
`timescale 1ns / 1ps
// qau_pkg: opcodes, operation classes, sequencer states and product schedules
// for the quaternion arithmetic unit. No dependencies.
package qau_pkg;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_CONJ  = 3'd3,
		OP_NORM  = 3'd4,
		OP_NRMLZ = 3'd5,
		OP_ROT   = 3'd6,
		OP_EQ    = 3'd7
	} qau_op_t;

	// how the back end handles an item
	typedef enum logic [1:0] {
		CLS_SIMPLE = 2'd0,
		CLS_MUL    = 2'd1,
		CLS_NORM   = 2'd2,
		CLS_ROT    = 2'd3
	} qau_cls_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_PROD = 3'd1,
		ST_SQRT = 3'd2,
		ST_DIV  = 3'd3,
		ST_EMIT = 3'd4
	} qau_state_t;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;

	localparam logic [4:0] NPROD_MUL  = 5'd16;
	localparam logic [4:0] NPROD_NORM = 5'd4;
	localparam logic [4:0] NPROD_ROT  = 5'd9;

	// one product: operand indexes, target accumulator, subtract flag
	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic [1:0] dst;
		logic       neg;
	} qau_step_t;

	function automatic qau_cls_t classify(input qau_op_t op);
		qau_cls_t c;
		unique case (op)
			OP_MUL:            c = CLS_MUL;
			OP_NORM, OP_NRMLZ: c = CLS_NORM;
			OP_ROT:            c = CLS_ROT;
			default:           c = CLS_SIMPLE;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] num_prod(input qau_cls_t cls);
		logic [4:0] n;
		unique case (cls)
			CLS_MUL:  n = NPROD_MUL;
			CLS_NORM: n = NPROD_NORM;
			CLS_ROT:  n = NPROD_ROT;
			default:  n = 5'd0;
		endcase
		return n;
	endfunction

	// Hamilton product terms, then squares, then the nine rotation products
	// xx yy zz xy xz yz wx wy wz (stored by step number)
	function automatic qau_step_t prod_step(input qau_cls_t cls, input logic [3:0] k);
		qau_step_t s;
		s = '{2'd0, 2'd0, 2'd0, 1'b0};
		unique case (cls)
			CLS_MUL: begin
				unique case (k)
					4'd0:  s = '{2'd0, 2'd0, 2'd0, 1'b0};
					4'd1:  s = '{2'd1, 2'd1, 2'd0, 1'b1};
					4'd2:  s = '{2'd2, 2'd2, 2'd0, 1'b1};
					4'd3:  s = '{2'd3, 2'd3, 2'd0, 1'b1};
					4'd4:  s = '{2'd0, 2'd1, 2'd1, 1'b0};
					4'd5:  s = '{2'd1, 2'd0, 2'd1, 1'b0};
					4'd6:  s = '{2'd2, 2'd3, 2'd1, 1'b0};
					4'd7:  s = '{2'd3, 2'd2, 2'd1, 1'b1};
					4'd8:  s = '{2'd0, 2'd2, 2'd2, 1'b0};
					4'd9:  s = '{2'd2, 2'd0, 2'd2, 1'b0};
					4'd10: s = '{2'd3, 2'd1, 2'd2, 1'b0};
					4'd11: s = '{2'd1, 2'd3, 2'd2, 1'b1};
					4'd12: s = '{2'd0, 2'd3, 2'd3, 1'b0};
					4'd13: s = '{2'd3, 2'd0, 2'd3, 1'b0};
					4'd14: s = '{2'd1, 2'd2, 2'd3, 1'b0};
					default: s = '{2'd2, 2'd1, 2'd3, 1'b1};
				endcase
			end
			CLS_NORM: s = '{k[1:0], k[1:0], 2'd0, 1'b0};
			CLS_ROT: begin
				unique case (k)
					4'd0: s = '{2'd1, 2'd1, 2'd0, 1'b0};
					4'd1: s = '{2'd2, 2'd2, 2'd0, 1'b0};
					4'd2: s = '{2'd3, 2'd3, 2'd0, 1'b0};
					4'd3: s = '{2'd1, 2'd2, 2'd0, 1'b0};
					4'd4: s = '{2'd1, 2'd3, 2'd0, 1'b0};
					4'd5: s = '{2'd2, 2'd3, 2'd0, 1'b0};
					4'd6: s = '{2'd0, 2'd1, 2'd0, 1'b0};
					4'd7: s = '{2'd0, 2'd2, 2'd0, 1'b0};
					default: s = '{2'd0, 2'd3, 2'd0, 1'b0};
				endcase
			end
			default: s = '{2'd0, 2'd0, 2'd0, 1'b0};
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/qau_if.sv
`timescale 1ns / 1ps
// qau_req_if / qau_rsp_if: valid/ready channels of the quaternion unit.
// Depends on nothing; W is the component width.
interface qau_req_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic [2:0]          opcode;
	logic signed [W-1:0] a_w;
	logic signed [W-1:0] a_x;
	logic signed [W-1:0] a_y;
	logic signed [W-1:0] a_z;
	logic signed [W-1:0] b_w;
	logic signed [W-1:0] b_x;
	logic signed [W-1:0] b_y;
	logic signed [W-1:0] b_z;

	modport source (output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		input ready);
	modport sink (input valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
		output ready);
endinterface

interface qau_rsp_if #(parameter int W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] res_w;
	logic signed [W-1:0] res_x;
	logic signed [W-1:0] res_y;
	logic signed [W-1:0] res_z;
	logic                is_equal;
	logic                zero_norm;
	logic                saturated;
	logic                last_row;

	modport source (output valid, res_w, res_x, res_y, res_z, is_equal, zero_norm,
		saturated, last_row, input ready);
	modport sink (input valid, res_w, res_x, res_y, res_z, is_equal, zero_norm,
		saturated, last_row, output ready);
endinterface

FILE: rtl/qau_front.sv
`timescale 1ns / 1ps
// qau_front: takes request beats, classifies the opcode and packs the entry
// for the queue. Depends on qau_pkg and qau_req_if.
module qau_front import qau_pkg::*; #(
	parameter int W  = 32,
	parameter int EW = 5 + 8 * W
) (
	qau_req_if.sink        req,
	input  logic           q_full,
	output logic           push,
	output logic [EW-1:0]  push_data
);

	qau_cls_t cls;

	assign cls       = classify(qau_op_t'(req.opcode));
	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;
	assign push_data = {cls, req.opcode, req.a_w, req.a_x, req.a_y, req.a_z,
		req.b_w, req.b_x, req.b_y, req.b_z};

endmodule

FILE: rtl/qau_queue.sv
`timescale 1ns / 1ps
// qau_queue: short register queue between the front and the back end.
// Depends on qau_pkg for its depth.
module qau_queue import qau_pkg::*; #(
	parameter int EW = 5 + 8 * 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [EW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output logic [EW-1:0] head
);

	logic [EW-1:0]     mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W + 1)'(QDEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

endmodule

FILE: rtl/qau_back.sv
`timescale 1ns / 1ps
// qau_back: sequencer that carries out one queued item at a time: shared
// multiplier, bit-serial square root, four divider lanes, output register.
// Depends on qau_pkg and qau_rsp_if.
module qau_back import qau_pkg::*; #(
	parameter int W  = 32,
	parameter int F  = 28,
	parameter int EW = 5 + 8 * 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [EW-1:0] q_head,
	output logic          pop,
	qau_rsp_if.source     rsp
);

	localparam int CW0     = 2 * W + 4;
	localparam int CW      = (F + 4 > CW0) ? F + 4 : CW0;
	localparam int SW      = 2 * W + 1;
	localparam int R       = W + 1;
	localparam int SRW     = R + 3;
	localparam int DW      = R + 1;
	localparam int QW      = F + 1;
	localparam int CNT_MAX = (R > QW) ? ((R > 16) ? R : 16) : ((QW > 16) ? QW : 16);
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam bit SUM_CAP = SW > 128;
	localparam logic [SW-1:0] SUM_LIM = {{(SW-1){1'b0}}, 1'b1} << 128;
	localparam logic signed [CW-1:0] HALF = {{(CW-1){1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1} << F;
	localparam logic signed [CW-1:0] MAXV =
		({{(CW-1){1'b0}}, 1'b1} << (W - 1)) - {{(CW-1){1'b0}}, 1'b1};
	localparam logic signed [CW-1:0] MINV = ~MAXV;

	function automatic logic signed [CW-1:0] ext(input logic signed [W-1:0] x);
		return {{(CW-W){x[W-1]}}, x};
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
		return x[W-1] ? W'(-x) : x;
	endfunction

	// {clipped flag, value}
	function automatic logic [W:0] clip(input logic signed [CW-1:0] v);
		if (v > MAXV)
			return {1'b1, MAXV[W-1:0]};
		else if (v < MINV)
			return {1'b1, MINV[W-1:0]};
		return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic signed [CW-1:0] dg(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] q);
		return ONE - ((p + q) <<< 1);
	endfunction

	function automatic logic signed [CW-1:0] od(input logic signed [CW-1:0] u,
		input logic signed [CW-1:0] v, input logic plus);
		return (plus ? u + v : u - v) <<< 1;
	endfunction

	qau_state_t state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       row_q;
	logic             out_valid_q;

	qau_cls_t cls_q;
	qau_op_t  op_q;
	logic signed [W-1:0]    a_q [4];
	logic signed [W-1:0]    b_q [4];
	logic signed [2*W-1:0]  prod_s1;
	logic [3:0]             tag_s1;
	logic signed [CW-1:0]   acc_q [4];
	logic signed [CW-1:0]   pr_q [9];
	logic [SW-1:0]          sum_q;
	logic [2*R-1:0]         sh_q;
	logic [SRW-1:0]         srem_q;
	logic [R-1:0]           root_q;
	logic [DW-1:0]          drem_q [4];
	logic [QW-1:0]          dq_q [4];

	logic signed [W-1:0] res_q [4];
	logic eq_q, zn_q, sat_q, last_q;

	logic [4:0]            nprod;
	logic                  prod_done, sqrt_done, div_done, issue;
	logic                  out_free, emit, e_last;
	qau_step_t             step, tstep;
	logic signed [W-1:0]   opa, opb;
	logic signed [2*W-1:0] prod_n;
	logic signed [CW-1:0]  pext, term;
	logic [SW-1:0]         sum_n, sum_cap;
	logic [SRW-1:0]        rem_sh, trial;
	logic                  sq_ge;
	logic [DW-1:0]         dt [4];
	logic                  dge [4];
	logic signed [CW-1:0]  v [4];
	logic [W:0]            c [4];
	logic                  e_eq, e_zn;
	logic [QW:0]           qr;
	logic                  rnd;

	assign nprod     = num_prod(cls_q);
	assign prod_done = cnt_q == CNT_W'(nprod);
	assign issue     = cnt_q < CNT_W'(nprod);
	assign sqrt_done = cnt_q == CNT_W'(R - 1);
	assign div_done  = cnt_q == CNT_W'(F);
	assign out_free  = !out_valid_q || rsp.ready;
	assign e_last    = (op_q != OP_ROT) || (row_q == 2'd2);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid)
				state_n = (qau_cls_t'(q_head[EW-1 -: 2]) == CLS_SIMPLE) ? ST_EMIT : ST_PROD;
			ST_PROD: if (prod_done)
				state_n = (cls_q == CLS_NORM) ? ST_SQRT : ST_EMIT;
			ST_SQRT: if (sqrt_done)
				state_n = (op_q == OP_NORM) ? ST_EMIT : ST_DIV;
			ST_DIV:  if (div_done)
				state_n = ST_EMIT;
			ST_EMIT: if (out_free && e_last)
				state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: pop  = q_valid;
			ST_EMIT: emit = out_free;
			default: ;
		endcase
	end

	// multiplier issue and rounding of the registered product
	always_comb begin
		step   = prod_step(cls_q, cnt_q[3:0]);
		tstep  = prod_step(cls_q, tag_s1);
		opa    = a_q[step.ia];
		opb    = (cls_q == CLS_MUL) ? b_q[step.ib] : a_q[step.ib];
		prod_n = opa * opb;
		pext   = {{(CW-2*W){prod_s1[2*W-1]}}, prod_s1};
		term   = (pext + HALF) >>> F;
		sum_n  = sum_q + {1'b0, prod_s1};
		sum_cap = (SUM_CAP && sum_n >= SUM_LIM) ? SUM_LIM - 1'b1 : sum_n;
	end

	// square root: one root bit per cycle
	always_comb begin
		rem_sh = {srem_q[SRW-3:0], sh_q[2*R-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		sq_ge  = rem_sh >= trial;
	end

	// divider lanes: one quotient bit per cycle, first step unshifted
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dt[i]  = (cnt_q == '0) ? drem_q[i] : {drem_q[i][DW-2:0], 1'b0};
			dge[i] = dt[i] >= {1'b0, root_q};
		end
	end

	// result of the current beat
	always_comb begin
		e_eq = 1'b0;
		e_zn = 1'b0;
		qr   = '0;
		rnd  = 1'b0;
		for (int i = 0; i < 4; i++)
			v[i] = '0;
		case (op_q)
			OP_ADD:  for (int i = 0; i < 4; i++) v[i] = ext(a_q[i]) + ext(b_q[i]);
			OP_SUB:  for (int i = 0; i < 4; i++) v[i] = ext(a_q[i]) - ext(b_q[i]);
			OP_CONJ: begin
				v[0] = ext(a_q[0]);
				for (int i = 1; i < 4; i++) v[i] = -ext(a_q[i]);
			end
			OP_MUL:  for (int i = 0; i < 4; i++) v[i] = acc_q[i];
			OP_NORM: v[0] = {{(CW-R){1'b0}}, root_q};
			OP_NRMLZ: begin
				if (root_q == '0) begin
					e_zn = 1'b1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						rnd  = {drem_q[i], 1'b0} >= {2'b00, root_q};
						qr   = {1'b0, dq_q[i]} + {{QW{1'b0}}, rnd};
						v[i] = a_q[i][W-1] ? -{{(CW-QW-1){1'b0}}, qr} : {{(CW-QW-1){1'b0}}, qr};
					end
				end
			end
			OP_ROT: begin
				v[0] = {{(CW-2){1'b0}}, row_q};
				case (row_q)
					2'd0: begin
						v[1] = dg(pr_q[1], pr_q[2]);
						v[2] = od(pr_q[3], pr_q[8], 1'b0);
						v[3] = od(pr_q[4], pr_q[7], 1'b1);
					end
					2'd1: begin
						v[1] = od(pr_q[3], pr_q[8], 1'b1);
						v[2] = dg(pr_q[0], pr_q[2]);
						v[3] = od(pr_q[5], pr_q[6], 1'b0);
					end
					default: begin
						v[1] = od(pr_q[4], pr_q[7], 1'b0);
						v[2] = od(pr_q[5], pr_q[6], 1'b1);
						v[3] = dg(pr_q[0], pr_q[1]);
					end
				endcase
			end
			default: e_eq = (a_q[0] == b_q[0]) && (a_q[1] == b_q[1]) &&
				(a_q[2] == b_q[2]) && (a_q[3] == b_q[3]);
		endcase
		for (int i = 0; i < 4; i++)
			c[i] = clip(v[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			case (state_q)
				ST_PROD: cnt_q <= prod_done ? '0 : cnt_q + 1'b1;
				ST_SQRT: cnt_q <= sqrt_done ? '0 : cnt_q + 1'b1;
				ST_DIV:  cnt_q <= div_done ? '0 : cnt_q + 1'b1;
				default: cnt_q <= '0;
			endcase
			if (pop)
				row_q <= '0;
			else if (emit && !e_last)
				row_q <= row_q + 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q <= qau_cls_t'(q_head[EW-1 -: 2]);
			op_q  <= qau_op_t'(q_head[EW-3 -: 3]);
			for (int i = 0; i < 4; i++) begin
				a_q[i]   <= q_head[(8-i)*W-1 -: W];
				b_q[i]   <= q_head[(4-i)*W-1 -: W];
				acc_q[i] <= '0;
			end
			sum_q <= '0;
		end
		if (state_q == ST_PROD) begin
			if (issue) begin
				prod_s1 <= prod_n;
				tag_s1  <= cnt_q[3:0];
			end
			if (cnt_q != '0) begin
				case (cls_q)
					CLS_MUL:  acc_q[tstep.dst] <= tstep.neg ? acc_q[tstep.dst] - term
						: acc_q[tstep.dst] + term;
					CLS_ROT:  pr_q[tag_s1] <= term;
					default:  sum_q <= sum_n;
				endcase
			end
			if (prod_done) begin
				sh_q   <= {{(2*R-SW){1'b0}}, sum_cap};
				srem_q <= '0;
				root_q <= '0;
			end
		end
		if (state_q == ST_SQRT) begin
			sh_q   <= sh_q << 2;
			srem_q <= sq_ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[R-2:0], sq_ge};
			if (sqrt_done) begin
				for (int i = 0; i < 4; i++) begin
					drem_q[i] <= {{(DW-W){1'b0}}, mag(a_q[i])};
					dq_q[i]   <= '0;
				end
			end
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < 4; i++) begin
				drem_q[i] <= dge[i] ? dt[i] - {1'b0, root_q} : dt[i];
				dq_q[i]   <= {dq_q[i][QW-2:0], dge[i]};
			end
		end
		if (emit) begin
			for (int i = 0; i < 4; i++)
				res_q[i] <= c[i][W-1:0];
			eq_q   <= e_eq;
			zn_q   <= e_zn;
			sat_q  <= c[0][W] | c[1][W] | c[2][W] | c[3][W];
			last_q <= e_last;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.res_w     = res_q[0];
	assign rsp.res_x     = res_q[1];
	assign rsp.res_y     = res_q[2];
	assign rsp.res_z     = res_q[3];
	assign rsp.is_equal  = eq_q;
	assign rsp.zero_norm = zn_q;
	assign rsp.saturated = sat_q;
	assign rsp.last_row  = last_q;

endmodule

FILE: rtl/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Beat
// req      in   opcode, A (a_w..a_z), B (b_w..b_z), signed fixed point
// rsp      out  res_w..res_z, is_equal, zero_norm, saturated, last_row
//
// Requests are taken into a two-entry queue whenever it has room, whatever the
// back end is doing. The back end runs one item at a time; products share a
// single multiplier, the rotation matrix comes out as three beats, and the
// root and divider loops give one bit per cycle. Results sit in an output
// register; a stalled rsp holds the back end only. Reset clears the queue and
// the sequencer.
module quaternion_arithmetic_unit import qau_pkg::*; #(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 28
) (
	input  logic      clk,
	input  logic      arst_n,
	qau_req_if.sink   req,
	qau_rsp_if.source rsp
);

	localparam int EW = 5 + 8 * COMPONENT_WIDTH;

	logic          push, q_full, pop, q_valid;
	logic [EW-1:0] push_data, q_head;

	qau_front #(.W(COMPONENT_WIDTH), .EW(EW)) u_front (
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	qau_queue #(.EW(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	qau_back #(.W(COMPONENT_WIDTH), .F(FRACTION_BITS), .EW(EW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule
